/* rtl/sac_pkg.sv */
// Shared types and constants for the sprite alpha compositor.
// No dependencies; imported by every module of the block.
`default_nettype none

package sac_pkg;

    localparam int unsigned DEF_MAX_DIM = 512;
    localparam int unsigned DIM_W       = 10;
    localparam int unsigned POS_W       = 11;
    localparam int unsigned PADDR_W     = 5;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned IDX_W       = 18;

    typedef enum logic [2:0] {
        REG_FB_WIDTH      = 3'd0,
        REG_FB_HEIGHT     = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_SPRITE_X      = 3'd4,
        REG_SPRITE_Y      = 3'd5,
        REG_BLEND_MODE    = 3'd6,
        REG_FADE_VALUE    = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        BM_OPAQUE = 2'd0,
        BM_KEY    = 2'd1,
        BM_BLEND  = 2'd2,
        BM_FADE   = 2'd3
    } t_blend_mode;

    localparam logic [DIM_W-1:0] RST_FB_WIDTH      = 10'd400;
    localparam logic [DIM_W-1:0] RST_FB_HEIGHT     = 10'd240;
    localparam logic [DIM_W-1:0] RST_SPRITE_WIDTH  = 10'd1;
    localparam logic [DIM_W-1:0] RST_SPRITE_HEIGHT = 10'd1;
    localparam logic [POS_W-1:0] RST_SPRITE_X      = 11'd0;
    localparam logic [POS_W-1:0] RST_SPRITE_Y      = 11'd0;
    localparam logic [7:0]       RST_FADE_VALUE    = 8'd255;

    typedef struct packed {
        logic [DIM_W-1:0] fb_width;
        logic [DIM_W-1:0] fb_height;
        logic [DIM_W-1:0] sprite_width;
        logic [DIM_W-1:0] sprite_height;
        logic [POS_W-1:0] sprite_x;
        logic [POS_W-1:0] sprite_y;
        t_blend_mode      blend_mode;
        logic [7:0]       fade_value;
    } t_cfg;

    typedef struct packed {
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] src_c0;
        logic [7:0] src_c1;
        logic [7:0] src_c2;
        logic [7:0] src_alpha;
        logic [7:0] dst_c0;
        logic [7:0] dst_c1;
        logic [7:0] dst_c2;
    } t_in_item;

    typedef struct packed {
        logic             write_enable;
        logic [IDX_W-1:0] fb_addr;
        logic [7:0]       out_c0;
        logic [7:0]       out_c1;
        logic [7:0]       out_c2;
    } t_out_item;

    // Stage load enables from the pipeline control.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_en;

endpackage

`default_nettype wire

/* rtl/sprite_alpha_compositor.sv */
// Top level of the sprite alpha compositor: APB registers, pipeline control, datapath.
// Depends on sac_pkg, sac_apb_regs, sac_pipe_ctl and sac_datapath.
`default_nettype none

// Per-pixel sprite compositor for a 24-bit framebuffer. Each input transaction
// carries one sprite pixel (column, row, three color bytes, alpha) plus the
// framebuffer color already at that spot; each output transaction carries the
// write enable, the framebuffer pixel index (screen_x + screen_y * fb_width,
// low 18 bits) and the color to store. Pixels outside the sprite size or the
// framebuffer, and zero-alpha pixels in every mode but opaque copy, come out
// with all fields zero. The pipeline is three register stages deep: clip and
// alpha scaling (fade multiply), then the per-channel source and destination
// products and the row-offset multiply, then the per-mode combine into the
// output register. One transaction is accepted per clock while the output
// is not stalled; a result is presented from the output register until it
// is taken. A stalled output only holds the stages that are full, so
// bubbles still fill behind it. Framebuffer width and height saturate at
// MAX_DIM for clipping and addressing.
// Configuration registers sit on the APB port at byte address 4*index; write
// them only while the pipeline is empty. pready is always high.

module sprite_alpha_compositor
    import sac_pkg::*;
#(
    parameter int unsigned MAX_DIM = DEF_MAX_DIM
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // pixel input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_data,
    // pixel output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_data
);

    t_cfg     w_cfg;
    t_pipe_en w_en;

    // Regs; user keeps values stable while transactions are in flight (unenforced).
    sac_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Valid bits per stage; advance a stage whenever the one after it can take data.
    sac_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_en        (w_en)
    );

    // Payload stages; the last stage is the output register.
    sac_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk  (i_clk),
        .i_cfg  (w_cfg),
        .i_en   (w_en),
        .i_item (i_in_data),
        .o_item (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/sac_apb_regs.sv */
// APB configuration register file for the sprite alpha compositor.
// Depends on sac_pkg.
`default_nettype none

module sac_apb_regs
    import sac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fb_width      <= RST_FB_WIDTH;
            r_cfg.fb_height     <= RST_FB_HEIGHT;
            r_cfg.sprite_width  <= RST_SPRITE_WIDTH;
            r_cfg.sprite_height <= RST_SPRITE_HEIGHT;
            r_cfg.sprite_x      <= RST_SPRITE_X;
            r_cfg.sprite_y      <= RST_SPRITE_Y;
            r_cfg.blend_mode    <= BM_OPAQUE;
            r_cfg.fade_value    <= RST_FADE_VALUE;
        end else if (w_wr) begin
            case (w_idx)
                REG_FB_WIDTH:      r_cfg.fb_width      <= pwdata[DIM_W-1:0];
                REG_FB_HEIGHT:     r_cfg.fb_height     <= pwdata[DIM_W-1:0];
                REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= pwdata[DIM_W-1:0];
                REG_SPRITE_HEIGHT: r_cfg.sprite_height <= pwdata[DIM_W-1:0];
                REG_SPRITE_X:      r_cfg.sprite_x      <= pwdata[POS_W-1:0];
                REG_SPRITE_Y:      r_cfg.sprite_y      <= pwdata[POS_W-1:0];
                REG_BLEND_MODE:    r_cfg.blend_mode    <= t_blend_mode'(pwdata[1:0]);
                REG_FADE_VALUE:    r_cfg.fade_value    <= pwdata[7:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_FB_WIDTH:      prdata = PDATA_W'(r_cfg.fb_width);
            REG_FB_HEIGHT:     prdata = PDATA_W'(r_cfg.fb_height);
            REG_SPRITE_WIDTH:  prdata = PDATA_W'(r_cfg.sprite_width);
            REG_SPRITE_HEIGHT: prdata = PDATA_W'(r_cfg.sprite_height);
            REG_SPRITE_X:      prdata = PDATA_W'(r_cfg.sprite_x);
            REG_SPRITE_Y:      prdata = PDATA_W'(r_cfg.sprite_y);
            REG_BLEND_MODE:    prdata = PDATA_W'(r_cfg.blend_mode);
            REG_FADE_VALUE:    prdata = PDATA_W'(r_cfg.fade_value);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sac_pipe_ctl.sv */
// Valid tracking and stall control for the three-stage compositor pipeline.
// Depends on sac_pkg.
`default_nettype none

module sac_pipe_ctl
    import sac_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_en  o_en
);

    logic r_vld1, r_vld2, r_vld3;
    logic n_vld1, n_vld2, n_vld3;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        o_en.en3 = !r_vld3 || i_out_ready;
        o_en.en2 = !r_vld2 || o_en.en3;
        o_en.en1 = !r_vld1 || o_en.en2;
        n_vld1   = o_en.en1 ? i_in_valid : r_vld1;
        n_vld2   = o_en.en2 ? r_vld1     : r_vld2;
        n_vld3   = o_en.en3 ? r_vld2     : r_vld3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= n_vld1;
            r_vld2 <= n_vld2;
            r_vld3 <= n_vld3;
        end
    end

    assign o_in_ready  = o_en.en1;
    assign o_out_valid = r_vld3;

endmodule

`default_nettype wire

/* rtl/sac_datapath.sv */
// Three-stage compositor datapath: clip and alpha scale, multiply, sum and select.
// Depends on sac_pkg; stage enables come from sac_pipe_ctl.
`default_nettype none

module sac_datapath
    import sac_pkg::*;
#(
    parameter int unsigned MAX_DIM = DEF_MAX_DIM
)(
    input  wire logic     i_clk,
    input  wire t_cfg     i_cfg,
    input  wire t_pipe_en i_en,
    input  wire t_in_item i_item,
    output t_out_item     o_item
);

    // Framebuffer dimensions saturate at MAX_DIM; beyond the register range it never bites.
    localparam int unsigned     SAT_DIM   = (MAX_DIM > 1023) ? 1023 : MAX_DIM;
    localparam logic [DIM_W-1:0] SAT_DIM_V = SAT_DIM[DIM_W-1:0];

    logic [DIM_W-1:0] w_fw, w_fh;
    assign w_fw = (i_cfg.fb_width  > SAT_DIM_V) ? SAT_DIM_V : i_cfg.fb_width;
    assign w_fh = (i_cfg.fb_height > SAT_DIM_V) ? SAT_DIM_V : i_cfg.fb_height;

    // ---------------- stage 1: screen position, clip, effective alpha
    logic [POS_W:0]   w_sx, w_sy;
    logic             w_clip_ok, w_we1;
    logic [15:0]      w_fade_prod;
    logic [7:0]       w_ea;

    logic             r_s1_we;
    logic [DIM_W-1:0] r_s1_sx, r_s1_sy;
    logic [7:0]       r_s1_ea;
    logic [7:0]       r_s1_s [3];
    logic [7:0]       r_s1_d [3];

    always_comb begin
        w_sx = {i_cfg.sprite_x[POS_W-1], i_cfg.sprite_x} + {3'b000, i_item.col};
        w_sy = {i_cfg.sprite_y[POS_W-1], i_cfg.sprite_y} + {3'b000, i_item.row};
        w_clip_ok = ({1'b0, i_item.col} < i_cfg.sprite_width)
                 && ({1'b0, i_item.row} < i_cfg.sprite_height)
                 && !w_sx[POS_W] && !w_sy[POS_W]
                 && (w_sx[POS_W-1:0] < {1'b0, w_fw})
                 && (w_sy[POS_W-1:0] < {1'b0, w_fh});
        // Transparent pixels are dropped in every mode but opaque copy.
        w_we1 = w_clip_ok
             && !((i_cfg.blend_mode != BM_OPAQUE) && (i_item.src_alpha == 8'd0));
        w_fade_prod = 16'(i_cfg.fade_value) * 16'(i_item.src_alpha);
        w_ea = (i_cfg.blend_mode == BM_FADE) ? w_fade_prod[15:8] : i_item.src_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_s1_we   <= w_we1;
            r_s1_sx   <= w_sx[DIM_W-1:0];
            r_s1_sy   <= w_sy[DIM_W-1:0];
            r_s1_ea   <= w_ea;
            r_s1_s[0] <= i_item.src_c0;
            r_s1_s[1] <= i_item.src_c1;
            r_s1_s[2] <= i_item.src_c2;
            r_s1_d[0] <= i_item.dst_c0;
            r_s1_d[1] <= i_item.dst_c1;
            r_s1_d[2] <= i_item.dst_c2;
        end
    end

    // ---------------- stage 2: channel products and row offset
    logic [2*DIM_W-1:0] w_row_off;
    assign w_row_off = (2*DIM_W)'(r_s1_sy) * (2*DIM_W)'(w_fw);

    logic             r_s2_we;
    logic [DIM_W-1:0] r_s2_sx;
    logic [IDX_W-1:0] r_s2_row_off;
    logic [15:0]      r_s2_ps [3];
    logic [15:0]      r_s2_pd [3];
    logic [7:0]       r_s2_s  [3];

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_s2_we      <= r_s1_we;
            r_s2_sx      <= r_s1_sx;
            r_s2_row_off <= w_row_off[IDX_W-1:0];
            for (int k = 0; k < 3; k++) begin
                r_s2_ps[k] <= 16'(r_s1_s[k]) * 16'(r_s1_ea);
                r_s2_pd[k] <= 16'(r_s1_d[k]) * 16'(8'd255 - r_s1_ea);
                r_s2_s[k]  <= r_s1_s[k];
            end
        end
    end

    // ---------------- stage 3: combine per mode, zero unwritten pixels
    logic [16:0] w_sum [3];
    logic [7:0]  w_col [3];
    t_out_item   n_out, r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = {1'b0, r_s2_ps[k]} + {1'b0, r_s2_pd[k]};
            case (i_cfg.blend_mode)
                BM_OPAQUE, BM_KEY: w_col[k] = r_s2_s[k];
                BM_BLEND:          w_col[k] = w_sum[k][15:8];
                BM_FADE:           w_col[k] = r_s2_ps[k][15:8] + r_s2_pd[k][15:8];
                default:           w_col[k] = r_s2_s[k];
            endcase
        end
        n_out.write_enable = r_s2_we;
        n_out.fb_addr      = r_s2_we ? (r_s2_row_off + IDX_W'(r_s2_sx)) : '0;
        n_out.out_c0       = r_s2_we ? w_col[0] : 8'd0;
        n_out.out_c1       = r_s2_we ? w_col[1] : 8'd0;
        n_out.out_c2       = r_s2_we ? w_col[2] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for sprite_alpha_compositor: directed and random pixel streams across
// register settings, each result checked against an in-bench compositing predictor.
// Depends on sac_pkg and the sprite_alpha_compositor RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;

    localparam int STALL_PCT     = 13;   // percent of cycles each side idles
    localparam int PIPE_DEPTH    = 3;    // register stages in the block
    localparam int N_RAND_PHASES = 8;
    localparam int RAND_ITEMS    = 66;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;

    // Pixels waiting to be sent, and the results predicted for accepted pixels.
    t_in_item  pending_pixels[$];
    t_out_item predicted_pixels[$];

    // Register image as the predictor sees it; updated on each APB write.
    t_cfg      shadow_cfg;
    bit        steady_flow = 1'b0;   // suppress idling on both sides
    int        errors      = 0;
    string     result_fields [5] = '{"write_enable", "fb_addr", "out_c0", "out_c1",
                                     "out_c2"};

    sprite_alpha_compositor #(
        .MAX_DIM     (DEF_MAX_DIM)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: clip the pixel against sprite and framebuffer, then mix
    // source and destination per the blend mode. Unwritten pixels give an
    // all-zero result.
    // ------------------------------------------------------------------
    function automatic t_out_item composite_pixel(t_in_item px, t_cfg c);
        int unsigned fb_w;
        int unsigned fb_h;
        int unsigned a;
        int unsigned a_faded;
        int          scr_x;
        int          scr_y;
        logic [7:0]  src [3];
        logic [7:0]  dst [3];
        int unsigned mix [3];
        logic        wr;
        t_out_item   r;
        // Framebuffer dimensions saturate at the maximum size.
        fb_w    = (c.fb_width  > DEF_MAX_DIM) ? DEF_MAX_DIM : c.fb_width;
        fb_h    = (c.fb_height > DEF_MAX_DIM) ? DEF_MAX_DIM : c.fb_height;
        scr_x   = int'($signed(c.sprite_x)) + int'(px.col);
        scr_y   = int'($signed(c.sprite_y)) + int'(px.row);
        src     = '{px.src_c0, px.src_c1, px.src_c2};
        dst     = '{px.dst_c0, px.dst_c1, px.dst_c2};
        a       = px.src_alpha;
        wr      = (px.col < c.sprite_width) && (px.row < c.sprite_height) &&
                  scr_x >= 0 && scr_y >= 0 && scr_x < int'(fb_w) && scr_y < int'(fb_h);
        // Every mode but opaque copy drops fully transparent pixels.
        if (c.blend_mode != BM_OPAQUE && a == 0) begin
            wr = 1'b0;
        end
        r = '0;
        if (wr) begin
            a_faded = (c.fade_value * a) >> 8;
            for (int k = 0; k < 3; k++) begin
                case (c.blend_mode)
                    BM_OPAQUE, BM_KEY: begin
                        mix[k] = src[k];
                    end
                    BM_BLEND: begin
                        mix[k] = (src[k] * a + dst[k] * (255 - a)) >> 8;
                    end
                    default: begin
                        mix[k] = ((src[k] * a_faded) >> 8) + ((dst[k] * (255 - a_faded)) >> 8);
                    end
                endcase
            end
            r.write_enable = 1'b1;
            r.fb_addr      = IDX_W'(scr_x + scr_y * int'(fb_w));
            r.out_c0       = 8'(mix[0]);
            r.out_c1       = 8'(mix[1]);
            r.out_c2       = 8'(mix[2]);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic t_in_item mk_px(int unsigned col, int unsigned row, logic [23:0] src,
                                       logic [7:0] alpha, logic [23:0] dst);
        t_in_item px;
        px = '{9'(col), 9'(row), src[23:16], src[15:8], src[7:0], alpha,
               dst[23:16], dst[15:8], dst[7:0]};
        return px;
    endfunction

    function automatic t_cfg mk_cfg(int unsigned fb_w, int unsigned fb_h, int unsigned spr_w,
                                    int unsigned spr_h, int pos_x, int pos_y,
                                    t_blend_mode mode, int unsigned fade);
        t_cfg c;
        c = '{DIM_W'(fb_w), DIM_W'(fb_h), DIM_W'(spr_w), DIM_W'(spr_h),
              POS_W'(pos_x), POS_W'(pos_y), mode, 8'(fade)};
        return c;
    endfunction

    // Mostly ordinary sizes, with zero, the saturation point and oversize mixed in.
    function automatic logic [DIM_W-1:0] pick_dim(int unsigned typical_max);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_W'($urandom_range(DEF_MAX_DIM + 1, 1023));
            2:       return DIM_W'(DEF_MAX_DIM);
            default: return DIM_W'($urandom_range(1, typical_max));
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   fb_span;
        int   spr_span;
        c.fb_width      = pick_dim(DEF_MAX_DIM);
        c.fb_height     = pick_dim(DEF_MAX_DIM);
        c.sprite_width  = pick_dim(48);
        c.sprite_height = pick_dim(48);
        // Place the sprite so that it can overlap a framebuffer edge.
        fb_span  = (c.fb_width > DEF_MAX_DIM) ? DEF_MAX_DIM : c.fb_width;
        spr_span = (c.sprite_width > 48) ? 48 : c.sprite_width;
        if ($urandom_range(0, 9) == 0) begin
            c.sprite_x = POS_W'($urandom);
        end else begin
            c.sprite_x = POS_W'(int'($urandom_range(0, fb_span + spr_span)) - spr_span);
        end
        fb_span  = (c.fb_height > DEF_MAX_DIM) ? DEF_MAX_DIM : c.fb_height;
        spr_span = (c.sprite_height > 48) ? 48 : c.sprite_height;
        if ($urandom_range(0, 9) == 0) begin
            c.sprite_y = POS_W'($urandom);
        end else begin
            c.sprite_y = POS_W'(int'($urandom_range(0, fb_span + spr_span)) - spr_span);
        end
        c.blend_mode = t_blend_mode'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0:       c.fade_value = 8'h00;
            1:       c.fade_value = 8'hFF;
            default: c.fade_value = 8'($urandom);
        endcase
        return c;
    endfunction

    // Most pixels fall inside or just past the sprite; the rest roam the full range.
    function automatic t_in_item rand_pixel(t_cfg c);
        logic [95:0] raw;
        t_in_item    px;
        int unsigned col_max;
        int unsigned row_max;
        raw     = {$urandom, $urandom, $urandom};
        px      = raw[$bits(t_in_item)-1:0];
        col_max = (c.sprite_width  + 3 > 511) ? 511 : c.sprite_width  + 3;
        row_max = (c.sprite_height + 3 > 511) ? 511 : c.sprite_height + 3;
        if ($urandom_range(0, 9) < 8) begin
            px.col = 9'($urandom_range(0, col_max));
            px.row = 9'($urandom_range(0, row_max));
        end
        case ($urandom_range(0, 4))
            0:       px.src_alpha = 8'h00;
            1:       px.src_alpha = 8'hFF;
            default: ;
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------
    // APB register access: setup cycle, then access cycle. The register
    // takes the value at the edge that ends the access cycle; mirror it
    // into the shadow image at that same edge.
    // ------------------------------------------------------------------
    task automatic apb_write(t_reg_idx idx, logic [PDATA_W-1:0] word);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FB_WIDTH:      shadow_cfg.fb_width      = word[DIM_W-1:0];
            REG_FB_HEIGHT:     shadow_cfg.fb_height     = word[DIM_W-1:0];
            REG_SPRITE_WIDTH:  shadow_cfg.sprite_width  = word[DIM_W-1:0];
            REG_SPRITE_HEIGHT: shadow_cfg.sprite_height = word[DIM_W-1:0];
            REG_SPRITE_X:      shadow_cfg.sprite_x      = word[POS_W-1:0];
            REG_SPRITE_Y:      shadow_cfg.sprite_y      = word[POS_W-1:0];
            REG_BLEND_MODE:    shadow_cfg.blend_mode    = t_blend_mode'(word[1:0]);
            default:           shadow_cfg.fade_value    = word[7:0];
        endcase
    endtask

    // Program every register; fill the unused upper bits with junk, which the
    // block must drop.
    task automatic program_regs(t_cfg c);
        apb_write(REG_FB_WIDTH,      ($urandom << DIM_W) | PDATA_W'(c.fb_width));
        apb_write(REG_FB_HEIGHT,     ($urandom << DIM_W) | PDATA_W'(c.fb_height));
        apb_write(REG_SPRITE_WIDTH,  ($urandom << DIM_W) | PDATA_W'(c.sprite_width));
        apb_write(REG_SPRITE_HEIGHT, ($urandom << DIM_W) | PDATA_W'(c.sprite_height));
        apb_write(REG_SPRITE_X,      ($urandom << POS_W) | PDATA_W'(c.sprite_x));
        apb_write(REG_SPRITE_Y,      ($urandom << POS_W) | PDATA_W'(c.sprite_y));
        apb_write(REG_BLEND_MODE,    ($urandom << 2)     | PDATA_W'(c.blend_mode));
        apb_write(REG_FADE_VALUE,    ($urandom << 8)     | PDATA_W'(c.fade_value));
    endtask

    // Hold until every queued pixel is sent and every predicted result is back.
    // Sample on the falling edge, once the driver and monitor have settled.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_pixels.size() != 0 || i_in_valid || predicted_pixels.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Input driver: predict on each accepted transaction, then load the next
    // pixel from the queue or idle. Valid only drops once the current
    // transaction has been taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_pixels.push_back(composite_pixel(i_in_data, shadow_cfg));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_pixels.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= STALL_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_pixels.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: stall the result side at random and compare each
    // accepted result, field by field, with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_out_item   want;
        logic [31:0] got_f  [5];
        logic [31:0] want_f [5];
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady_flow || ($urandom_range(0, 99) >= STALL_PCT);
            if (o_out_valid && i_out_ready) begin
                if (predicted_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, got %h", $time, o_out_data);
                end else begin
                    want = predicted_pixels.pop_front();
                    if (o_out_data !== want) begin
                        errors++;
                        got_f  = '{32'(o_out_data.write_enable), 32'(o_out_data.fb_addr),
                                   32'(o_out_data.out_c0), 32'(o_out_data.out_c1),
                                   32'(o_out_data.out_c2)};
                        want_f = '{32'(want.write_enable), 32'(want.fb_addr),
                                   32'(want.out_c0), 32'(want.out_c1), 32'(want.out_c2)};
                        for (int k = 0; k < 5; k++) begin
                            if (got_f[k] !== want_f[k]) begin
                                $display("%0t: %s expected %0h got %0h", $time,
                                         result_fields[k], want_f[k], got_f[k]);
                            end
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg cfg;
        shadow_cfg = '{RST_FB_WIDTH, RST_FB_HEIGHT, RST_SPRITE_WIDTH, RST_SPRITE_HEIGHT,
                       RST_SPRITE_X, RST_SPRITE_Y, BM_OPAQUE, RST_FADE_VALUE};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 1x1 opaque sprite at the origin; only (0,0) lands.
        pending_pixels.push_back(mk_px(0, 0, 24'h123456, 8'h00, 24'hABCDEF));
        pending_pixels.push_back(mk_px(1, 0, 24'h123456, 8'h80, 24'hABCDEF));
        pending_pixels.push_back(mk_px(0, 1, 24'h123456, 8'h80, 24'hABCDEF));
        drain();

        // Oversize framebuffer saturates; far corner gives the largest index.
        program_regs(mk_cfg(1023, 1023, 1023, 1023, 0, 0, BM_OPAQUE, 0));
        pending_pixels.push_back(mk_px(511, 511, 24'hFFFFFF, 8'h00, 24'h000000));
        pending_pixels.push_back(mk_px(0, 0, 24'h000000, 8'hFF, 24'hFFFFFF));
        drain();

        // Alpha key on a single-pixel framebuffer: transparent, barely opaque, off sprite.
        program_regs(mk_cfg(1, 1, 1, 1, 0, 0, BM_KEY, 255));
        pending_pixels.push_back(mk_px(0, 0, 24'hFFFFFF, 8'h00, 24'h000000));
        pending_pixels.push_back(mk_px(0, 0, 24'h5AA55A, 8'h01, 24'hC33C00));
        pending_pixels.push_back(mk_px(511, 0, 24'h5AA55A, 8'hFF, 24'hC33C00));
        drain();

        // Zero-width framebuffer: nothing may be written.
        program_regs(mk_cfg(0, 512, 512, 512, 0, 0, BM_BLEND, 255));
        pending_pixels.push_back(mk_px(0, 0, 24'hFFFFFF, 8'hFF, 24'h000000));
        drain();

        // Sprite at the most negative column and the last row: fully off screen.
        program_regs(mk_cfg(320, 200, 16, 16, -1024, 1023, BM_BLEND, 255));
        pending_pixels.push_back(mk_px(15, 0, 24'hFFFFFF, 8'hFF, 24'h000000));
        pending_pixels.push_back(mk_px(0, 15, 24'hFFFFFF, 8'hFF, 24'h000000));
        drain();

        // Blend with the sprite hanging off the top-left corner.
        program_regs(mk_cfg(320, 200, 16, 16, -5, -3, BM_BLEND, 128));
        pending_pixels.push_back(mk_px(4, 3, 24'hFFFFFF, 8'hFF, 24'h000000));
        pending_pixels.push_back(mk_px(5, 3, 24'hFFFFFF, 8'hFF, 24'h000000));
        pending_pixels.push_back(mk_px(5, 2, 24'hFFFFFF, 8'hFF, 24'h000000));
        pending_pixels.push_back(mk_px(15, 15, 24'h80C0FF, 8'h80, 24'hFF4000));
        pending_pixels.push_back(mk_px(16, 3, 24'h80C0FF, 8'h80, 24'hFF4000));
        pending_pixels.push_back(mk_px(5, 3, 24'h80C0FF, 8'h00, 24'hFF4000));
        drain();

        // Fade blend at full fade near the bottom-right corner.
        program_regs(mk_cfg(400, 240, 512, 512, 390, 230, BM_FADE, 255));
        pending_pixels.push_back(mk_px(9, 9, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
        pending_pixels.push_back(mk_px(10, 9, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
        pending_pixels.push_back(mk_px(0, 0, 24'h123456, 8'h01, 24'hFEDCBA));
        pending_pixels.push_back(mk_px(0, 0, 24'h123456, 8'h00, 24'hFEDCBA));
        drain();

        // Zero fade: scaled alpha vanishes but the pixel is still written.
        program_regs(mk_cfg(400, 240, 4, 4, 0, 0, BM_FADE, 0));
        pending_pixels.push_back(mk_px(3, 3, 24'hFFFFFF, 8'hFF, 24'hFFFFFF));
        drain();

        // Random phases: fresh settings each time, one phase with no idling and
        // one where the sender holds mid-stream until the pipe runs dry.
        for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
            cfg = rand_cfg();
            program_regs(cfg);
            steady_flow = (ph == 3);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (ph == 5 && n == RAND_ITEMS / 2) begin
                    drain();
                end
                pending_pixels.push_back(rand_pixel(cfg));
            end
            drain();
        end
        steady_flow = 1'b0;

        // Let any stray result surface before the verdict.
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
